FILE: hdl/fdf_pkg.sv
// package: types, constants and microprogram of the flood relay duplicate filter
`timescale 1ns / 1ps

package fdf_pkg;

  localparam int SEEN_DEPTH_DEF = 32;
  localparam int RELAY_FLAG_BIT = 0;
  localparam logic [7:0] RELAY_MASK = 8'(1 << RELAY_FLAG_BIT);

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_OWN_NODE_ID  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_RELAY_ENABLE = 1'b1;

  typedef struct packed {
    logic [15:0] source_node;
    logic [15:0] sequence_number;
    logic [7:0]  hops_left;
    logic [7:0]  packet_flags;
  } fdf_in_t;

  typedef struct packed {
    logic       forward;
    logic [7:0] hops_out;
    logic [7:0] flags_out;
  } fdf_out_t;

  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_CHECK,
    STEP_SCAN,
    STEP_DECIDE,
    STEP_INSERT,
    STEP_FWD,
    STEP_DROP
  } step_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_NOT_QUAL,
    COND_SCAN_BUSY,
    COND_SEEN,
    COND_OUT_BUSY
  } cond_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_INIT,
    ACT_SCAN,
    ACT_INSERT,
    ACT_EMIT_FWD,
    ACT_EMIT_DROP
  } act_t;

  typedef struct packed {
    logic  accept;
    act_t  act;
    cond_t cond;
    step_t jump;
    step_t next;
  } fdf_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic not_qual;
    logic scan_busy;
    logic seen;
    logic out_busy;
  } fdf_status_t;

  // microprogram rom: jump when the condition holds, else go to next
  function automatic fdf_ctrl_t fdf_program(input step_t step);
    fdf_ctrl_t w;
    w = '{accept: 1'b0, act: ACT_NONE, cond: COND_ALWAYS, jump: STEP_IDLE, next: STEP_IDLE};
    unique case (step)
      STEP_IDLE:   w = '{1'b1, ACT_LOAD,      COND_IN_VALID,  STEP_CHECK, STEP_IDLE};
      STEP_CHECK:  w = '{1'b0, ACT_INIT,      COND_NOT_QUAL,  STEP_DROP,  STEP_SCAN};
      STEP_SCAN:   w = '{1'b0, ACT_SCAN,      COND_SCAN_BUSY, STEP_SCAN,  STEP_DECIDE};
      STEP_DECIDE: w = '{1'b0, ACT_NONE,      COND_SEEN,      STEP_DROP,  STEP_INSERT};
      STEP_INSERT: w = '{1'b0, ACT_INSERT,    COND_ALWAYS,    STEP_FWD,   STEP_FWD};
      STEP_FWD:    w = '{1'b0, ACT_EMIT_FWD,  COND_OUT_BUSY,  STEP_FWD,   STEP_IDLE};
      STEP_DROP:   w = '{1'b0, ACT_EMIT_DROP, COND_OUT_BUSY,  STEP_DROP,  STEP_IDLE};
      default:     w = '{1'b0, ACT_NONE,      COND_ALWAYS,    STEP_IDLE,  STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/fdf_sequencer.sv
// microcode sequencer: step counter, program rom and condition select
`timescale 1ns / 1ps

module fdf_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  fdf_pkg::fdf_status_t status,
  output fdf_pkg::fdf_ctrl_t  ctrl
);

  fdf_pkg::step_t step;
  fdf_pkg::step_t step_next;
  logic           cond_true;

  always_comb begin
    ctrl = fdf_pkg::fdf_program(step);
  end

  always_comb begin
    cond_true = 1'b0;
    unique case (ctrl.cond)
      fdf_pkg::COND_ALWAYS:    cond_true = 1'b1;
      fdf_pkg::COND_IN_VALID:  cond_true = status.in_valid;
      fdf_pkg::COND_NOT_QUAL:  cond_true = status.not_qual;
      fdf_pkg::COND_SCAN_BUSY: cond_true = status.scan_busy;
      fdf_pkg::COND_SEEN:      cond_true = status.seen;
      fdf_pkg::COND_OUT_BUSY:  cond_true = status.out_busy;
      default:                 cond_true = 1'b0;
    endcase
    step_next = cond_true ? ctrl.jump : ctrl.next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= fdf_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

FILE: hdl/fdf_datapath.sv
// datapath: header register, key ring memory, scan compare and output register
`timescale 1ns / 1ps

module fdf_datapath #(
  parameter int SEEN_DEPTH = fdf_pkg::SEEN_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  fdf_pkg::fdf_ctrl_t                  ctrl,
  output fdf_pkg::fdf_status_t                status,
  input  logic                                cfg_write,
  input  logic [fdf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [fdf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  input  fdf_pkg::fdf_in_t                    in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fdf_pkg::fdf_out_t                   out_word
);

  localparam int IDX_W = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
  localparam int CNT_W = $clog2(SEEN_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL     = CNT_W'(SEEN_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEEN_DEPTH - 1);

  logic [31:0]      mem [SEEN_DEPTH];
  logic [31:0]      rdata;
  fdf_pkg::fdf_in_t item;
  logic [31:0]      key;
  logic [CNT_W-1:0] scan_idx;
  logic             rd_pend;
  logic             seen;
  logic [IDX_W-1:0] ptr;
  logic [CNT_W-1:0] fill;
  logic [15:0]      own_node_id;
  logic             relay_enable;
  logic             rd_issue;
  logic             wr_en;
  logic             emit;

  assign key      = {item.source_node, item.sequence_number};
  assign rd_issue = (ctrl.act == fdf_pkg::ACT_SCAN) && (scan_idx < fill);
  assign wr_en    = (ctrl.act == fdf_pkg::ACT_INSERT);
  assign emit     = ((ctrl.act == fdf_pkg::ACT_EMIT_FWD) || (ctrl.act == fdf_pkg::ACT_EMIT_DROP))
                    && !status.out_busy;

  always_comb begin
    status.in_valid  = in_valid;
    status.not_qual  = !relay_enable || (item.source_node == own_node_id) ||
                       (item.hops_left == 8'd0);
    status.scan_busy = (scan_idx < fill) || rd_pend;
    status.seen      = seen;
    status.out_busy  = out_valid && out_stall;
  end

  // key ring, only entries below the fill count have been written
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ptr] <= key;
    end
    if (rd_issue) begin
      rdata <= mem[scan_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept && in_valid) begin
      item <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx     <= '0;
      rd_pend      <= 1'b0;
      seen         <= 1'b0;
      ptr          <= '0;
      fill         <= '0;
      own_node_id  <= 16'd0;
      relay_enable <= 1'b1;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          fdf_pkg::REG_OWN_NODE_ID:  own_node_id  <= cfg_data;
          fdf_pkg::REG_RELAY_ENABLE: relay_enable <= cfg_data[0];
          default: ;
        endcase
      end
      case (ctrl.act)
        fdf_pkg::ACT_INIT: begin
          scan_idx <= '0;
          rd_pend  <= 1'b0;
          // the zero key counts as seen while the ring is not full
          seen     <= (key == 32'd0) && (fill != FULL);
        end
        fdf_pkg::ACT_SCAN: begin
          rd_pend <= rd_issue;
          if (rd_issue) begin
            scan_idx <= scan_idx + CNT_W'(1);
          end
          if (rd_pend && (rdata == key)) begin
            seen <= 1'b1;
          end
        end
        fdf_pkg::ACT_INSERT: begin
          ptr <= (ptr == LAST_IDX) ? '0 : ptr + IDX_W'(1);
          if (fill != FULL) begin
            fill <= fill + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (ctrl.act == fdf_pkg::ACT_EMIT_FWD) begin
        out_word.forward   <= 1'b1;
        out_word.hops_out  <= item.hops_left - 8'd1;
        out_word.flags_out <= item.packet_flags | fdf_pkg::RELAY_MASK;
      end else begin
        out_word <= '0;
      end
    end
  end

endmodule

FILE: hdl/flood_relay_duplicate_filter.sv
// top level of the flood relay duplicate filter
`timescale 1ns / 1ps

// Takes one received packet header per input word and returns one decision
// word. A packet is forwarded when relay mode is on, its source is not this
// node, its hop count is non-zero and its key {source_node, sequence_number}
// is not among the last SEEN_DEPTH forwarded keys. A forwarded word carries
// the hop count minus one and the relay flag set; a dropped word is all
// zeros. The zero key, source 0 with sequence 0, counts as seen until
// the ring has filled once. The ring memory has one read port and the
// scan reads one stored key per cycle, then waits for the last read to
// return. A duplicate skips the insert, and a header that fails the mode,
// source or hop test skips the scan. A new decision waits while the
// output register still holds an earlier one that is stalled.
// Headers are handled one at a time; the decision sits in an output
// register so the next header can be taken while it waits.

module flood_relay_duplicate_filter #(
  parameter int SEEN_DEPTH = fdf_pkg::SEEN_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration writes
  input  logic                            cfg_write,
  input  logic [fdf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fdf_pkg::CFG_DATA_W-1:0]  cfg_data,
  // header words in
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fdf_pkg::fdf_in_t                in_word,
  // decision words out
  output logic                            out_valid,
  input  logic                            out_stall,
  output fdf_pkg::fdf_out_t               out_word
);

  fdf_pkg::fdf_ctrl_t   ctrl;
  fdf_pkg::fdf_status_t status;

  // only the idle step takes a header
  assign in_stall = !ctrl.accept;

  fdf_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  fdf_datapath #(
    .SEEN_DEPTH (SEEN_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .status    (status),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
